// ===== design/sbc_pkg.sv =====
// Shared types and constants for the segment box clipper.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sbc_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_MUL,
    ST_ADD,
    ST_DONE
  } sbc_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic div_start;
    logic mul_start;
    logic move_pt;
    logic snap_pt;
    logic finish_hit;
    logic finish_miss;
    logic finish_exh;
  } sbc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic code_zero;
    logic code_shared;
    logic use_div;
    logic div_done;
    logic mul_done;
  } sbc_stat_t;

  localparam logic [2:0] REG_MIN_X = 3'd0;
  localparam logic [2:0] REG_MIN_Y = 3'd1;
  localparam logic [2:0] REG_MIN_Z = 3'd2;
  localparam logic [2:0] REG_MAX_X = 3'd3;
  localparam logic [2:0] REG_MAX_Y = 3'd4;
  localparam logic [2:0] REG_MAX_Z = 3'd5;
  localparam logic [2:0] REG_MIN_DIR = 3'd6;

endpackage
`default_nettype wire

// ===== design/sbc_ctrl.sv =====
// Controller state machine of the segment box clipper.
// Depends on sbc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sbc_ctrl import sbc_pkg::*; #(
  parameter int CLIP_ROUNDS = 4
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  wire        out_ready,
  input  sbc_stat_t  stat,
  output sbc_cmd_t   cmd
);

  localparam int RW = $clog2(CLIP_ROUNDS + 1);

  sbc_state_t state_r, state_nxt;
  logic [RW-1:0] round_r, round_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      round_r <= '0;
    end else begin
      state_r <= state_nxt;
      round_r <= round_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    round_nxt = round_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) begin
        state_nxt = ST_EVAL;
        round_nxt = '0;
      end
      ST_EVAL: begin
        if (round_r == RW'(CLIP_ROUNDS) || stat.code_zero || stat.code_shared) begin
          state_nxt = ST_DONE;
        end else if (stat.use_div) begin
          state_nxt = ST_DIV;
        end else begin
          round_nxt = round_r + 1'b1;
        end
      end
      ST_DIV: if (stat.div_done) state_nxt = ST_MUL;
      ST_MUL: if (stat.mul_done) state_nxt = ST_ADD;
      ST_ADD: begin
        state_nxt = ST_EVAL;
        round_nxt = round_r + 1'b1;
      end
      ST_DONE: if (out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_EVAL: begin
        if (round_r == RW'(CLIP_ROUNDS)) cmd.finish_exh = 1'b1;
        else if (stat.code_zero) cmd.finish_hit = 1'b1;
        else if (stat.code_shared) cmd.finish_miss = 1'b1;
        else if (stat.use_div) cmd.div_start = 1'b1;
        else cmd.snap_pt = 1'b1;
      end
      ST_DIV: cmd.mul_start = stat.div_done;
      ST_MUL: ;
      ST_ADD: cmd.move_pt = 1'b1;
      ST_DONE: out_valid = 1'b1;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== design/sbc_datapath.sv =====
// Datapath of the segment box clipper: point registers, outcodes, a bit-serial
// divider and a shared multiplier stepped over the three axes.
// Depends on sbc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sbc_datapath import sbc_pkg::*; #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  sbc_cmd_t                     cmd,
  output sbc_stat_t                    stat,
  input  wire                          cfg_we,
  input  wire [2:0]                    cfg_index,
  input  wire [COORD_WIDTH-1:0]        cfg_data,
  input  wire signed [COORD_WIDTH-1:0] in_org [3],
  input  wire signed [COORD_WIDTH-1:0] in_dir [3],
  input  wire signed [COORD_WIDTH-1:0] in_start [3],
  input  wire signed [COORD_WIDTH-1:0] in_end [3],
  output logic                         res_hit,
  output logic signed [COORD_WIDTH-1:0] res_pt [3],
  output logic [5:0]                   res_faces
);

  localparam int W  = COORD_WIDTH;
  localparam int NW = W + 1;            // magnitude of a coordinate difference
  localparam int QW = NW + FRAC_BITS;   // quotient width
  localparam int QCW = $clog2(QW + 1);
  localparam logic [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};

  // Configuration registers.
  logic signed [W-1:0] lo_r [3];
  logic signed [W-1:0] hi_r [3];
  logic [W-2:0] thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < 3; a++) begin
        lo_r[a] <= '0;
        hi_r[a] <= W'(65536);
      end
      thr_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MIN_X: lo_r[0] <= cfg_data;
        REG_MIN_Y: lo_r[1] <= cfg_data;
        REG_MIN_Z: lo_r[2] <= cfg_data;
        REG_MAX_X: hi_r[0] <= cfg_data;
        REG_MAX_Y: hi_r[1] <= cfg_data;
        REG_MAX_Z: hi_r[2] <= cfg_data;
        REG_MIN_DIR: thr_r <= cfg_data[W-2:0];
        default: ;
      endcase
    end
  end

  // Item registers.
  logic signed [W-1:0] org_r [3];
  logic signed [W-1:0] dir_r [3];
  logic signed [W-1:0] pt_r [3];
  logic [5:0] end_code_r;

  function automatic logic [5:0] outc(input logic signed [W-1:0] p [3],
                                      input logic signed [W-1:0] lo [3],
                                      input logic signed [W-1:0] hi [3]);
    logic [5:0] c;
    c = '0;
    for (int a = 0; a < 3; a++) begin
      if (p[a] < lo[a]) c[2*a] = 1'b1;
      else if (p[a] > hi[a]) c[2*a+1] = 1'b1;
    end
    return c;
  endfunction

  function automatic logic [5:0] faces(input logic signed [W-1:0] p [3],
                                       input logic signed [W-1:0] lo [3],
                                       input logic signed [W-1:0] hi [3]);
    logic [5:0] c;
    c = '0;
    for (int a = 0; a < 3; a++) begin
      if (p[a] == lo[a]) c[2*a] = 1'b1;
      else if (p[a] == hi[a]) c[2*a+1] = 1'b1;
    end
    return c;
  endfunction

  // Outcode and plane choice for the current point.
  logic [5:0] code;
  logic [1:0] ax;
  logic       is_hi;
  logic signed [W-1:0] bound;
  logic signed [W-1:0] dsel;
  logic [W-1:0] dmag;

  always_comb begin
    code = outc(pt_r, lo_r, hi_r);
    ax = 2'd2;
    is_hi = code[5];
    if (code[0] || code[1]) begin
      ax = 2'd0;
      is_hi = !code[0];
    end else if (code[2] || code[3]) begin
      ax = 2'd1;
      is_hi = !code[2];
    end else if (code[4]) begin
      is_hi = 1'b0;
    end
    bound = is_hi ? hi_r[ax] : lo_r[ax];
    dsel = dir_r[ax];
    dmag = dsel[W-1] ? W'(-dsel) : W'(dsel);
  end

  assign stat.code_zero   = (code == 6'd0);
  assign stat.code_shared = |(code & end_code_r);
  assign stat.use_div     = dmag > {1'b0, thr_r};

  // Bit-serial restoring divider: |num| << FRAC_BITS over |den|.
  logic [QW-1:0]  dividend_r;
  logic [W:0]     rem_r;
  logic [W-1:0]   den_r;
  logic [QCW-1:0] qcnt_r;
  logic           div_busy_r;
  logic           qneg_r;
  logic [1:0]     ax_r;
  logic signed [W-1:0] bound_r;
  logic signed [NW-1:0] num;
  logic [NW-1:0]  nmag;
  logic [W+1:0]   trial;

  always_comb begin
    num = NW'(bound) - NW'(org_r[ax]);
    nmag = num[NW-1] ? NW'(-num) : num;
    trial = {rem_r, dividend_r[QW-1]} - {2'b00, den_r};
  end

  assign stat.div_done = div_busy_r && (qcnt_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
    end else if (cmd.div_start) begin
      div_busy_r <= 1'b1;
    end else if (stat.div_done) begin
      div_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dividend_r <= {nmag, {FRAC_BITS{1'b0}}};
      rem_r <= '0;
      den_r <= dmag;
      qcnt_r <= QCW'(QW);
      qneg_r <= num[NW-1] != dsel[W-1];
      ax_r <= ax;
      bound_r <= bound;
    end else if (div_busy_r && qcnt_r != '0) begin
      qcnt_r <= qcnt_r - 1'b1;
      if (!trial[W+1]) begin
        rem_r <= trial[W:0];
        dividend_r <= {dividend_r[QW-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[W-1:0], dividend_r[QW-1]};
        dividend_r <= {dividend_r[QW-2:0], 1'b0};
      end
    end
  end

  // Saturated plane parameter as sign and magnitude.
  logic [W-1:0] smag;
  always_comb begin
    if (dividend_r > QW'(CMAX)) smag = qneg_r ? {1'b1, {(W-1){1'b0}}} : CMAX;
    else smag = dividend_r[W-1:0];
  end

  // Shared multiplier, stepped over the axes one after another, partial products in halves.
  localparam int HW = (W + 1) / 2;
  logic [W-1:0]   s_r;
  logic           sneg_r;
  logic [1:0]     mk_r;
  logic           mhalf_r;
  logic           mul_busy_r;
  logic [2*W-1:0] prod_r [3];
  logic [W-1:0]   m_dmag;
  logic [HW+W-1:0] pp;

  always_comb begin
    m_dmag = dir_r[mk_r][W-1] ? W'(-dir_r[mk_r]) : W'(dir_r[mk_r]);
    pp = mhalf_r ? (HW+W)'(m_dmag[W-1:HW]) * (HW+W)'(s_r)
                 : (HW+W)'(m_dmag[HW-1:0]) * (HW+W)'(s_r);
  end

  assign stat.mul_done = mul_busy_r && mk_r == 2'd2 && mhalf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_busy_r <= 1'b0;
    end else if (cmd.mul_start) begin
      mul_busy_r <= 1'b1;
    end else if (stat.mul_done) begin
      mul_busy_r <= 1'b0;
    end
  end

  // The multiplier works on |s|; the sign is applied when the point is updated.
  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      s_r <= smag;
      sneg_r <= qneg_r;
      mk_r <= 2'd0;
      mhalf_r <= 1'b0;
    end else if (mul_busy_r) begin
      if (mhalf_r) begin
        prod_r[mk_r] <= prod_r[mk_r] + ((2*W)'(pp) << HW);
        mk_r <= (mk_r == 2'd2) ? 2'd0 : mk_r + 1'b1;
      end else begin
        prod_r[mk_r] <= (2*W)'(pp);
      end
      mhalf_r <= !mhalf_r;
    end
  end

  // Point update and results.
  logic signed [W+1:0] sum [3];
  logic signed [W-1:0] newc [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic [2*W-1:0] p;
      logic [W+1:0]   pm;
      logic           neg;
      p = prod_r[k] >> FRAC_BITS;
      pm = (p > (2*W)'({2'b01, {W{1'b0}}})) ? {2'b01, {W{1'b0}}} : p[W+1:0];
      neg = dir_r[k][W-1] != sneg_r;
      sum[k] = (W+2)'(org_r[k]) + (neg ? -$signed(pm) : $signed(pm));
      if (sum[k] > $signed((W+2)'(CMAX))) newc[k] = CMAX;
      else if (sum[k] < -$signed((W+2)'(CMAX)) - 1) newc[k] = {1'b1, {(W-1){1'b0}}};
      else newc[k] = sum[k][W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int a = 0; a < 3; a++) begin
        org_r[a] <= in_org[a];
        dir_r[a] <= in_dir[a];
        pt_r[a] <= in_start[a];
      end
      end_code_r <= outc(in_end, lo_r, hi_r);
    end else if (cmd.snap_pt) begin
      pt_r[ax] <= bound;
    end else if (cmd.move_pt) begin
      for (int k = 0; k < 3; k++)
        pt_r[k] <= (k == int'(ax_r)) ? bound_r : newc[k];
    end
    if (cmd.finish_hit || cmd.finish_miss || cmd.finish_exh) begin
      res_hit <= !cmd.finish_miss;
      res_faces <= cmd.finish_exh ? 6'd0 : faces(pt_r, lo_r, hi_r);
    end
  end

  assign res_pt = pt_r;

endmodule
`default_nettype wire

// ===== design/segment_box_clip_core.sv =====
// Top level of the segment box clipper: controller plus datapath.
// Depends on sbc_pkg, sbc_ctrl and sbc_datapath.
//
//   channel | ports         | moves
//   in      | in_valid/ready| line origin, direction, segment ends
//   out     | out_valid/rdy | hit, clipped point, face bits
//   cfg     | cfg_we        | box bounds and snap threshold
//
// One item at a time. Each round passes through an evaluation state; a round that
// intersects a plane adds the bit-serial divider, the shared multiplier and
// an update state. After a result is taken the controller returns to idle,
// and only there is the next input taken.
// Reset is synchronous, active low. A result holds until out_ready.
`timescale 1ns / 1ps
`default_nettype none
module segment_box_clip_core import sbc_pkg::*; #(
  parameter int CLIP_ROUNDS = 4,
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          cfg_we,
  input  wire [2:0]                    cfg_index,
  input  wire [COORD_WIDTH-1:0]        cfg_data,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire signed [COORD_WIDTH-1:0] in_line_origin_x,
  input  wire signed [COORD_WIDTH-1:0] in_line_origin_y,
  input  wire signed [COORD_WIDTH-1:0] in_line_origin_z,
  input  wire signed [COORD_WIDTH-1:0] in_line_dir_x,
  input  wire signed [COORD_WIDTH-1:0] in_line_dir_y,
  input  wire signed [COORD_WIDTH-1:0] in_line_dir_z,
  input  wire signed [COORD_WIDTH-1:0] in_seg_start_x,
  input  wire signed [COORD_WIDTH-1:0] in_seg_start_y,
  input  wire signed [COORD_WIDTH-1:0] in_seg_start_z,
  input  wire signed [COORD_WIDTH-1:0] in_seg_end_x,
  input  wire signed [COORD_WIDTH-1:0] in_seg_end_y,
  input  wire signed [COORD_WIDTH-1:0] in_seg_end_z,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic                         out_hit,
  output logic signed [COORD_WIDTH-1:0] out_clip_x,
  output logic signed [COORD_WIDTH-1:0] out_clip_y,
  output logic signed [COORD_WIDTH-1:0] out_clip_z,
  output logic [5:0]                   out_face_bits
);

  sbc_cmd_t  cmd;
  sbc_stat_t stat;
  logic signed [COORD_WIDTH-1:0] org [3];
  logic signed [COORD_WIDTH-1:0] dir [3];
  logic signed [COORD_WIDTH-1:0] st [3];
  logic signed [COORD_WIDTH-1:0] en [3];
  logic signed [COORD_WIDTH-1:0] pt [3];

  assign org = '{in_line_origin_x, in_line_origin_y, in_line_origin_z};
  assign dir = '{in_line_dir_x, in_line_dir_y, in_line_dir_z};
  assign st  = '{in_seg_start_x, in_seg_start_y, in_seg_start_z};
  assign en  = '{in_seg_end_x, in_seg_end_y, in_seg_end_z};
  assign out_clip_x = pt[0];
  assign out_clip_y = pt[1];
  assign out_clip_z = pt[2];

  sbc_ctrl #(.CLIP_ROUNDS(CLIP_ROUNDS)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
    .stat, .cmd
  );

  sbc_datapath #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk, .rst_n, .cmd, .stat, .cfg_we, .cfg_index, .cfg_data,
    .in_org(org), .in_dir(dir), .in_start(st), .in_end(en),
    .res_hit(out_hit), .res_pt(pt), .res_faces(out_face_bits)
  );

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for segment_box_clip_core: random and directed segments
// clipped against a configurable box, checked against an in-bench fixed-point clipper.
// Depends on sbc_pkg and the segment_box_clip_core RTL.
`timescale 1ns / 1ps

typedef longint unsigned ulong_t;

typedef struct {
  logic signed [31:0] org[3];
  logic signed [31:0] dir[3];
  logic signed [31:0] st[3];
  logic signed [31:0] en[3];
} seg_item_t;

typedef struct {
  logic               hit;
  logic signed [31:0] pt[3];
  logic [5:0]         faces;
} clip_res_t;

// Holds the box settings and the queue of predicted clip results.
class clip_scoreboard;
  longint            box_lo[3];
  longint            box_hi[3];
  longint            thr;
  clip_res_t         clip_q[$];
  int                mismatches;

  function new();
    for (int a = 0; a < 3; a++) begin
      box_lo[a] = 0;
      box_hi[a] = 65536;
    end
    thr = 0;
    mismatches = 0;
  endfunction

  function void set_reg(logic [2:0] idx, logic [31:0] val);
    case (idx)
      sbc_pkg::REG_MIN_X: box_lo[0] = longint'(signed'(val));
      sbc_pkg::REG_MIN_Y: box_lo[1] = longint'(signed'(val));
      sbc_pkg::REG_MIN_Z: box_lo[2] = longint'(signed'(val));
      sbc_pkg::REG_MAX_X: box_hi[0] = longint'(signed'(val));
      sbc_pkg::REG_MAX_Y: box_hi[1] = longint'(signed'(val));
      sbc_pkg::REG_MAX_Z: box_hi[2] = longint'(signed'(val));
      sbc_pkg::REG_MIN_DIR: thr = longint'({33'd0, val[30:0]});
      default: ;
    endcase
  endfunction

  function longint umag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function longint capped(longint unsigned m, bit neg);
    if (m > (64'd1 << 62)) m = 64'd1 << 62;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function int outc(longint p[3]);
    int c;
    c = 0;
    for (int a = 0; a < 3; a++) begin
      if (p[a] < box_lo[a]) c |= 1 << (2 * a);
      else if (p[a] > box_hi[a]) c |= 2 << (2 * a);
    end
    return c;
  endfunction

  function int facec(longint p[3]);
    int c;
    c = 0;
    for (int a = 0; a < 3; a++) begin
      if (p[a] == box_lo[a]) c |= 1 << (2 * a);
      else if (p[a] == box_hi[a]) c |= 2 << (2 * a);
    end
    return c;
  endfunction

  // Runs up to four clip rounds on an accepted transaction and queues the result.
  function void note_input(seg_item_t it);
    longint pt[3], ep[3], org[3], dir[3];
    longint bound, s;
    longint unsigned q, p;
    int endc, code, b, ax;
    bit done;
    clip_res_t r;
    for (int a = 0; a < 3; a++) begin
      org[a] = it.org[a];
      dir[a] = it.dir[a];
      pt[a]  = it.st[a];
      ep[a]  = it.en[a];
    end
    endc = outc(ep);
    done = 0;
    r.hit = 1'b1;
    r.faces = 6'd0;
    for (int rd = 0; rd < 4 && !done; rd++) begin
      code = outc(pt);
      if (code == 0) begin
        r.hit = 1'b1; r.faces = 6'(facec(pt)); done = 1;
      end else if ((code & endc) != 0) begin
        r.hit = 1'b0; r.faces = 6'(facec(pt)); done = 1;
      end else begin
        b = 0;
        while (b < 5 && !code[b]) b++;
        ax = b >> 1;
        bound = (b & 1) ? box_hi[ax] : box_lo[ax];
        if (umag(dir[ax]) > thr) begin
          q = (ulong_t'(umag(bound - org[ax])) << 16) / ulong_t'(umag(dir[ax]));
          s = sat32(capped(q, ((bound - org[ax]) < 0) != (dir[ax] < 0)));
          for (int k = 0; k < 3; k++) begin
            if (k == ax) pt[k] = bound;
            else begin
              p = (ulong_t'(umag(dir[k])) * ulong_t'(umag(s))) >> 16;
              pt[k] = sat32(org[k] + capped(p, (dir[k] < 0) != (s < 0)));
            end
          end
        end else begin
          pt[ax] = bound;
        end
      end
    end
    if (!done) begin
      r.hit = 1'b1;
      r.faces = 6'd0;
    end
    for (int a = 0; a < 3; a++) r.pt[a] = pt[a][31:0];
    clip_q.push_back(r);
  endfunction

  // Compares one accepted result with the oldest prediction.
  function void check(clip_res_t got);
    clip_res_t e;
    if (clip_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("ERROR: result with no transaction pending");
      return;
    end
    e = clip_q.pop_front();
    if (got.hit !== e.hit || got.pt[0] !== e.pt[0] || got.pt[1] !== e.pt[1] ||
        got.pt[2] !== e.pt[2] || got.faces !== e.faces) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: exp hit=%0d pt=%h %h %h faces=%h, got hit=%0d pt=%h %h %h faces=%h",
                 e.hit, e.pt[0], e.pt[1], e.pt[2], e.faces,
                 got.hit, got.pt[0], got.pt[1], got.pt[2], got.faces);
    end
  endfunction
endclass

module testbench;
  import sbc_pkg::*;

  logic clk, rst_n;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;
  logic in_valid, in_ready, out_valid, out_ready;
  logic signed [31:0] in_org[3], in_dir[3], in_st[3], in_en[3];
  logic out_hit;
  logic signed [31:0] out_clip_x, out_clip_y, out_clip_z;
  logic [5:0] out_face_bits;
  logic hold_req;

  clip_scoreboard sb;

  segment_box_clip_core dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_line_origin_x(in_org[0]), .in_line_origin_y(in_org[1]),
    .in_line_origin_z(in_org[2]),
    .in_line_dir_x(in_dir[0]), .in_line_dir_y(in_dir[1]), .in_line_dir_z(in_dir[2]),
    .in_seg_start_x(in_st[0]), .in_seg_start_y(in_st[1]), .in_seg_start_z(in_st[2]),
    .in_seg_end_x(in_en[0]), .in_seg_end_y(in_en[1]), .in_seg_end_z(in_en[2]),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_hit(out_hit), .out_clip_x(out_clip_x), .out_clip_y(out_clip_y),
    .out_clip_z(out_clip_z), .out_face_bits(out_face_bits)
  );

  // Clock generation.
  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Hard limit on the run time.
  initial begin
    #20000000;
    $display("segment_box_clip_core verification failed");
    $finish;
  end

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    out_ready = 0;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        out_ready = 0;
        repeat (400) @(negedge clk);
        hold_req = 0;
      end else begin
        out_ready = 1;
        @(negedge clk);
        if ($urandom_range(0, 3) == 0) begin
          out_ready = 0;
          repeat (rand_gap()) @(negedge clk);
        end
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    clip_res_t got;
    if (rst_n && out_valid && out_ready) begin
      got.hit = out_hit;
      got.pt[0] = out_clip_x;
      got.pt[1] = out_clip_y;
      got.pt[2] = out_clip_z;
      got.faces = out_face_bits;
      sb.check(got);
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = val;
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_we = 0;
  endtask

  // Withdraws the input, waits for every pending result, then lets the block settle.
  task automatic drain();
    @(negedge clk);
    in_valid = 0;
    while (sb.clip_q.size() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  task automatic load_box(longint lo[3], longint hi[3], logic [31:0] t);
    write_reg(REG_MIN_X, lo[0][31:0]);
    write_reg(REG_MIN_Y, lo[1][31:0]);
    write_reg(REG_MIN_Z, lo[2][31:0]);
    write_reg(REG_MAX_X, hi[0][31:0]);
    write_reg(REG_MAX_Y, hi[1][31:0]);
    write_reg(REG_MAX_Z, hi[2][31:0]);
    write_reg(REG_MIN_DIR, {1'b0, t[30:0]});
  endtask

  // Presents one transaction and holds it until accepted.
  task automatic send_item(seg_item_t it);
    @(negedge clk);
    in_valid = 1;
    for (int a = 0; a < 3; a++) begin
      in_org[a] = it.org[a];
      in_dir[a] = it.dir[a];
      in_st[a] = it.st[a];
      in_en[a] = it.en[a];
    end
    do @(posedge clk); while (!in_ready);
    sb.note_input(it);
    if (rand_gap() != 0 || $urandom_range(0, 1) == 0) begin
      @(negedge clk);
      in_valid = 0;
      repeat (rand_gap()) @(negedge clk);
    end
  endtask

  function automatic logic signed [31:0] near_coord(int a);
    longint span, c;
    span = sb.box_hi[a] - sb.box_lo[a];
    if (span < 0) span = -span;
    if (span < 16) span = 16;
    if (span > (64'sd1 << 30)) span = 64'sd1 << 30;
    c = sb.box_lo[a] + longint'($urandom_range(0, 32'(span * 3))) - span;
    return 32'(sb.sat32(c));
  endfunction

  // Well-formed segments near the box, occasional tiny or zero direction, some noise.
  function automatic seg_item_t rand_item();
    seg_item_t it;
    int mode;
    mode = $urandom_range(0, 9);
    for (int a = 0; a < 3; a++) begin
      if (mode < 7) begin
        it.st[a] = near_coord(a);
        it.en[a] = near_coord(a);
        it.org[a] = ($urandom_range(0, 3) == 0) ? near_coord(a) : it.st[a];
        it.dir[a] = 32'(sb.sat32(longint'(it.en[a]) - longint'(it.st[a])));
        if ($urandom_range(0, 7) == 0) it.dir[a] = $urandom_range(0, 8) - 4;
      end else begin
        it.org[a] = $urandom;
        it.dir[a] = $urandom;
        it.st[a] = $urandom;
        it.en[a] = $urandom;
      end
    end
    return it;
  endfunction

  function automatic seg_item_t mk_item(longint o, longint d, longint s, longint e);
    seg_item_t it;
    for (int a = 0; a < 3; a++) begin
      it.org[a] = o[31:0];
      it.dir[a] = d[31:0];
      it.st[a] = s[31:0];
      it.en[a] = e[31:0];
    end
    return it;
  endfunction

  initial begin
    seg_item_t it;
    longint lo[3], hi[3];
    sb = new();
    rst_n = 0;
    hold_req = 0;
    cfg_we = 0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 0;
    for (int a = 0; a < 3; a++) begin
      in_org[a] = 0; in_dir[a] = 0; in_st[a] = 0; in_en[a] = 0;
    end
    repeat (8) @(negedge clk);
    rst_n = 1;

    // Directed cases on the reset box: inside, same-side miss, crossing,
    // zero direction snap, and field extremes.
    send_item(mk_item(32768, 0, 32768, 32768));
    send_item(mk_item(-65536, 0, -65536, -131072));
    send_item(mk_item(-65536, 65536, -65536, 131072));
    send_item(mk_item(-65536, 196608, -65536, 131072));
    send_item(mk_item(0, 0, -65536, 131072));
    send_item(mk_item(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648,
                      64'sd2147483647));
    send_item(mk_item(64'sd2147483647, 64'sd2147483647, 64'sd2147483647,
                      -64'sd2147483648));
    send_item(mk_item(64'sd2147483647, -64'sd2147483648, 64'sd2147483647,
                      64'sd2147483647));
    send_item(mk_item(0, 1, 65536, 0));
    send_item(mk_item(-1, -1, -1, -1));
    it = mk_item(-131072, 65536, -131072, 196608);
    it.org[1] = 200000; it.st[1] = 200000; it.en[1] = -100000; it.dir[1] = -300000;
    it.org[2] = -70000; it.st[2] = -70000; it.en[2] = 140000; it.dir[2] = 210000;
    send_item(it);
    drain();

    // Random phases, each with its own box and threshold.
    for (int ph = 0; ph < 8; ph++) begin
      for (int a = 0; a < 3; a++) begin
        case (ph)
          0: begin lo[a] = -262144; hi[a] = 262144; end
          1: begin lo[a] = -64'sd2147483648; hi[a] = 64'sd2147483647; end
          2: begin lo[a] = 100000; hi[a] = -100000; end
          3: begin lo[a] = 65536; hi[a] = 65536; end
          4: begin lo[a] = 64'sd2147483647 - 65536; hi[a] = 64'sd2147483647; end
          default: begin
            lo[a] = longint'(signed'(32'($urandom_range(0, 4000000)))) - 2000000;
            hi[a] = lo[a] + $urandom_range(1, 3000000);
          end
        endcase
      end
      case (ph)
        0: load_box(lo, hi, 0);
        1: load_box(lo, hi, 32'h7fffffff);
        2: load_box(lo, hi, 1000);
        5: load_box(lo, hi, $urandom_range(0, 200000));
        default: load_box(lo, hi, $urandom_range(0, 16));
      endcase
      for (int n = 0; n < 200; n++) begin
        if (ph == 3 && n == 20) hold_req = 1;
        send_item(rand_item());
      end
      drain();
    end

    // Put the reset box back and run a last batch on it.
    for (int a = 0; a < 3; a++) begin
      lo[a] = 0; hi[a] = 65536;
    end
    load_box(lo, hi, 0);
    for (int n = 0; n < 20; n++) send_item(rand_item());
    drain();

    if (sb.mismatches == 0 && sb.clip_q.size() == 0) begin
      $display("segment_box_clip_core verification clean");
    end else begin
      $display("segment_box_clip_core verification failed");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
design/sbc_pkg.sv
design/sbc_ctrl.sv
design/sbc_datapath.sv
design/segment_box_clip_core.sv
test/testbench.sv
